/* hw/rtl/bwt_pkg.sv */
// Package: shared constants, codes and types of the breakpoint/watchpoint trigger table.
package bwt_pkg;

  localparam int BP_ENTRIES = 8;
  localparam int WP_ENTRIES = 8;
  localparam int MAX_OUT    = 8;

  localparam int BP_IW  = (BP_ENTRIES > 1) ? $clog2(BP_ENTRIES) : 1;
  localparam int WP_IW  = (WP_ENTRIES > 1) ? $clog2(WP_ENTRIES) : 1;
  localparam int SCAN_W = (BP_IW > WP_IW) ? BP_IW : WP_IW;
  localparam int CNT_W  = $clog2(MAX_OUT + 1);

  localparam logic [2:0] CMD_ADD_BP  = 3'd0;
  localparam logic [2:0] CMD_DEL_BP  = 3'd1;
  localparam logic [2:0] CMD_ADD_WP  = 3'd2;
  localparam logic [2:0] CMD_DEL_WP  = 3'd3;
  localparam logic [2:0] CMD_CHK_PC  = 3'd4;
  localparam logic [2:0] CMD_CHK_ACC = 3'd5;

  localparam logic [2:0] PT_SW_BP    = 3'd0;
  localparam logic [2:0] PT_HW_BP    = 3'd1;
  localparam logic [2:0] PT_WRITE_WP = 3'd2;
  localparam logic [2:0] PT_READ_WP  = 3'd3;
  localparam logic [2:0] PT_ACC_WP   = 3'd4;

  localparam logic [1:0] SK_NONE   = 2'd0;
  localparam logic [1:0] SK_BP     = 2'd0;
  localparam logic [1:0] SK_WRITE  = 2'd1;
  localparam logic [1:0] SK_READ   = 2'd2;
  localparam logic [1:0] SK_ACCESS = 2'd3;

  typedef struct packed {
    logic       del_hit;
    logic       bp_hit;
    logic [1:0] wp_kind;
  } match_t;

endpackage

/* hw/rtl/bwt_match.sv */
// Shared compare unit: matches one table entry against the current request.
module bwt_match (
  input  logic [2:0]      ptype,
  input  logic [63:0]     addr,
  input  logic [63:0]     len,
  input  logic [63:0]     hi,
  input  logic            is_write,
  input  logic [2:0]      e_kind,
  input  logic [63:0]     e_addr,
  input  logic [63:0]     e_len,
  output bwt_pkg::match_t m
);
  import bwt_pkg::*;

  logic addr_eq;
  logic in_range;

  always_comb begin
    addr_eq   = (e_addr == addr);
    in_range  = (e_addr >= addr) && (e_addr <= hi);
    m.del_hit = (e_kind == ptype) && addr_eq && (e_len == len);
    m.bp_hit  = addr_eq && ((e_kind == PT_SW_BP) || (e_kind == PT_HW_BP));
    m.wp_kind = SK_NONE;
    if (in_range) begin
      if (e_kind == PT_WRITE_WP && is_write) begin
        m.wp_kind = SK_WRITE;
      end else if (e_kind == PT_READ_WP && !is_write) begin
        m.wp_kind = SK_READ;
      end else if (e_kind == PT_ACC_WP) begin
        m.wp_kind = SK_ACCESS;
      end
    end
  end

endmodule

/* hw/rtl/breakpoint_watchpoint_trigger_table_unit.sv */
// Top level: breakpoint and watchpoint tables with a sequential scan engine.
// Usage:
//   Input channel (in_valid/in_ready) carries one request: add, delete,
//   pc check or access check. Output channel (out_valid/out_ready) returns
//   the results; adds and deletes give one, checks give one per hit (up to
//   eight) or a single empty result, the final one flagged by last.
// Timing:
//   in_ready is high only while the sequencer is idle. After acceptance the
//   shared compare unit visits one table slot per cycle while no hit is
//   stalled, and the final result is loaded from the done state once the
//   output register is free; the sequencer then returns to idle and takes the
//   next request. An add stops at the first free slot; unknown commands go
//   straight to the done state and give a single empty result.
//   Results sit in an output register, so the next request is accepted while
//   the final result waits to be taken.
// Stall:
//   When the receiver holds out_ready low, the scan pauses at the next hit
//   and resumes once the output register drains; nothing is dropped.
// Reset:
//   rst clears all valid bits (table, held hit and output) and the sequencer.
module breakpoint_watchpoint_trigger_table_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  command,
  input  logic [2:0]  point_type,
  input  logic [63:0] address,
  input  logic [63:0] length,
  input  logic        access_kind,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        add_ok,
  output logic        hit,
  output logic [1:0]  stop_kind,
  output logic [63:0] report_address,
  output logic [2:0]  entry_index,
  output logic        last
);
  import bwt_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_DONE = 3'b100
  } state_t;

  state_t state;

  logic [BP_ENTRIES-1:0] bp_valid;
  logic [2:0]            bp_kind [BP_ENTRIES];
  logic [63:0]           bp_addr [BP_ENTRIES];
  logic [63:0]           bp_len  [BP_ENTRIES];
  logic [WP_ENTRIES-1:0] wp_valid;
  logic [2:0]            wp_kind [WP_ENTRIES];
  logic [63:0]           wp_addr [WP_ENTRIES];
  logic [63:0]           wp_len  [WP_ENTRIES];

  logic [2:0]        cmd;
  logic [2:0]        ptype;
  logic [63:0]       addr;
  logic [63:0]       len;
  logic [63:0]       hi;
  logic              is_write;
  logic [SCAN_W-1:0] idx;
  logic              add_done;
  logic              held_valid;
  logic [1:0]        held_kind;
  logic [2:0]        held_idx;
  logic [CNT_W-1:0]  hit_cnt;

  logic              use_wp;
  logic              e_valid;
  logic [2:0]        e_kind;
  logic [63:0]       e_addr;
  logic [63:0]       e_len;
  logic              at_end;
  logic              out_free;
  logic              hit_now;
  logic [1:0]        hit_kind;
  logic              out_load;
  match_t            m;

  bwt_match u_match (
    .ptype    (ptype),
    .addr     (addr),
    .len      (len),
    .hi       (hi),
    .is_write (is_write),
    .e_kind   (e_kind),
    .e_addr   (e_addr),
    .e_len    (e_len),
    .m        (m)
  );

  always_comb begin
    use_wp = (cmd == CMD_ADD_WP) || (cmd == CMD_DEL_WP) || (cmd == CMD_CHK_ACC);
    if (use_wp) begin
      e_valid = wp_valid[idx[WP_IW-1:0]];
      e_kind  = wp_kind[idx[WP_IW-1:0]];
      e_addr  = wp_addr[idx[WP_IW-1:0]];
      e_len   = wp_len[idx[WP_IW-1:0]];
      at_end  = (idx == SCAN_W'(WP_ENTRIES - 1));
    end else begin
      e_valid = bp_valid[idx[BP_IW-1:0]];
      e_kind  = bp_kind[idx[BP_IW-1:0]];
      e_addr  = bp_addr[idx[BP_IW-1:0]];
      e_len   = bp_len[idx[BP_IW-1:0]];
      at_end  = (idx == SCAN_W'(BP_ENTRIES - 1));
    end
    out_free = !out_valid || out_ready;
    if (cmd == CMD_CHK_PC) begin
      hit_now  = e_valid && m.bp_hit;
      hit_kind = SK_BP;
    end else begin
      hit_now  = e_valid && (m.wp_kind != SK_NONE);
      hit_kind = m.wp_kind;
    end
    out_load = ((state == S_SCAN) && ((cmd == CMD_CHK_PC) || (cmd == CMD_CHK_ACC)) &&
                hit_now && held_valid && out_free) ||
               ((state == S_DONE) && out_free);
  end

  assign in_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      bp_valid   <= '0;
      wp_valid   <= '0;
      out_valid  <= 1'b0;
      held_valid <= 1'b0;
    end else begin
      out_valid <= out_load || (out_valid && !out_ready);
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            cmd        <= command;
            ptype      <= point_type;
            addr       <= address;
            len        <= length;
            hi         <= address + length;
            is_write   <= access_kind;
            idx        <= '0;
            add_done   <= 1'b0;
            held_valid <= 1'b0;
            hit_cnt    <= '0;
            state      <= S_SCAN;
          end
        end
        S_SCAN: begin
          unique case (cmd)
            CMD_ADD_BP, CMD_ADD_WP: begin
              if (!e_valid) begin
                if (use_wp) begin
                  wp_valid[idx[WP_IW-1:0]] <= 1'b1;
                  wp_kind[idx[WP_IW-1:0]]  <= ptype;
                  wp_addr[idx[WP_IW-1:0]]  <= addr;
                  wp_len[idx[WP_IW-1:0]]   <= len;
                end else begin
                  bp_valid[idx[BP_IW-1:0]] <= 1'b1;
                  bp_kind[idx[BP_IW-1:0]]  <= ptype;
                  bp_addr[idx[BP_IW-1:0]]  <= addr;
                  bp_len[idx[BP_IW-1:0]]   <= len;
                end
                add_done <= 1'b1;
                state    <= S_DONE;
              end else if (at_end) begin
                state <= S_DONE;
              end else begin
                idx <= idx + 1'b1;
              end
            end
            CMD_DEL_BP, CMD_DEL_WP: begin
              if (e_valid && m.del_hit) begin
                if (use_wp) begin
                  wp_valid[idx[WP_IW-1:0]] <= 1'b0;
                end else begin
                  bp_valid[idx[BP_IW-1:0]] <= 1'b0;
                end
              end
              if (at_end) begin
                state <= S_DONE;
              end else begin
                idx <= idx + 1'b1;
              end
            end
            CMD_CHK_PC, CMD_CHK_ACC: begin
              // a hit is held back one step so the final one can carry last
              if (!(hit_now && held_valid && !out_free)) begin
                if (hit_now) begin
                  if (held_valid) begin
                    add_ok         <= 1'b0;
                    hit            <= 1'b1;
                    stop_kind      <= held_kind;
                    report_address <= addr;
                    entry_index    <= held_idx;
                    last           <= 1'b0;
                  end
                  held_valid <= 1'b1;
                  held_kind  <= hit_kind;
                  held_idx   <= 3'(idx);
                  hit_cnt    <= hit_cnt + 1'b1;
                end
                if (at_end || (hit_now && hit_cnt == CNT_W'(MAX_OUT - 1))) begin
                  state <= S_DONE;
                end else begin
                  idx <= idx + 1'b1;
                end
              end
            end
            default: begin
              state <= S_DONE;
            end
          endcase
        end
        S_DONE: begin
          if (out_free) begin
            add_ok    <= add_done;
            last      <= 1'b1;
            if (held_valid) begin
              hit            <= 1'b1;
              stop_kind      <= held_kind;
              report_address <= addr;
              entry_index    <= held_idx;
            end else begin
              hit            <= 1'b0;
              stop_kind      <= SK_NONE;
              report_address <= '0;
              entry_index    <= '0;
            end
            held_valid <= 1'b0;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
